// File: src/numeric_literal_parser_defines.svh
// Assertion macros shared by the numeric literal parser RTL.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef NUMERIC_LITERAL_PARSER_DEFINES_SVH
`define NUMERIC_LITERAL_PARSER_DEFINES_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define NLP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define NLP_ASSERT_NEXT(label, trig, cons, msg) \
   `NLP_ASSERT(label, (trig) |=> (cons), msg)

`endif

// File: src/nlp_pkg.sv
// Package for the numeric literal parser: radix codes, character codes,
// sizes and the character-to-digit mapping. Depends on nothing.
package nlp_pkg;

   localparam int DefaultValueWidth = 64;
   localparam int FracWidth         = 6;
   localparam int PosWidth          = 2;

   localparam logic [FracWidth-1:0] FracMax = '1;
   localparam logic [PosWidth-1:0]  PosMax  = '1;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   localparam logic [7:0] CharMinus  = 8'h2D;  // '-'
   localparam logic [7:0] CharPoint  = 8'h2E;  // '.'
   localparam logic [7:0] CharZero   = 8'h30;  // '0'
   localparam logic [7:0] CharNine   = 8'h39;  // '9'
   localparam logic [7:0] CharUpA    = 8'h41;  // 'A'
   localparam logic [7:0] CharUpB    = 8'h42;  // 'B'
   localparam logic [7:0] CharUpF    = 8'h46;  // 'F'
   localparam logic [7:0] CharUpX    = 8'h58;  // 'X'
   localparam logic [7:0] CharLowA   = 8'h61;  // 'a'
   localparam logic [7:0] CharLowB   = 8'h62;  // 'b'
   localparam logic [7:0] CharLowF   = 8'h66;  // 'f'
   localparam logic [7:0] CharLowX   = 8'h78;  // 'x'

   // Map a character to its digit value; anything not 0-9, a-f, A-F is 0.
   function automatic logic [3:0] digit_of(input logic [7:0] code);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (code >= CharZero && code <= CharNine) begin
            diff = code - CharZero;
         end else if (code >= CharLowA && code <= CharLowF) begin
            diff = code - CharLowA + 8'd10;
         end else if (code >= CharUpA && code <= CharUpF) begin
            diff = code - CharUpA + 8'd10;
         end
         return diff[3:0];
      end
   endfunction

endpackage

// File: src/numeric_literal_parser.sv
// Numeric literal parser top level: character stream in, one parsed number out.
// Depends on nlp_pkg and numeric_literal_parser_defines.svh.
//
// Usage
//   req_ channel: one character per transfer (req_char_code) with req_last_char
//     set on the final character of a literal. A leading '-' sets the sign;
//     0x/0X selects hex, 0b/0B binary, a lone leading 0 octal, else decimal.
//     A '.' after the first stripped character that is followed by another
//     character turns the literal into a float, read in decimal throughout.
//   rsp_ channel: one transfer per literal, produced by its last character.
//     rsp_value is the signed integer wrapped to VALUE_WIDTH bits, or the
//     unsigned decimal mantissa for a float with rsp_fraction_digits as scale.
// Timing
//   Each character updates the parse state in the cycle it is transferred; the
//   result register is loaded on the same edge, so rsp_valid rises in the cycle
//   after the last character. One character per cycle while req_ready is high,
//   set by the single shift-and-add step between the state and result registers.
// Reset and stall
//   Reset clears the parse state and empties the result register. While a
//   result waits on rsp_ready low, req_ready drops; a result taken in the same
//   cycle frees the register, so no bubble appears.
module numeric_literal_parser #(
   parameter int VALUE_WIDTH = nlp_pkg::DefaultValueWidth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_char_code,
   input  logic                           req_last_char,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [VALUE_WIDTH-1:0]         rsp_value,
   output logic                           rsp_is_float,
   output logic                           rsp_negative,
   output logic [nlp_pkg::FracWidth-1:0]  rsp_fraction_digits
);
   import nlp_pkg::*;

   `include "numeric_literal_parser_defines.svh"

   // Parse state
   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic                   minus_ff, minus_in;
   radix_type              kind_ff, kind_in;
   logic [VALUE_WIDTH-1:0] dec_acc_ff, dec_acc_in;
   logic [VALUE_WIDTH-1:0] rad_acc_ff, rad_acc_in;
   logic [FracWidth-1:0]   frac_ff, frac_in;
   logic                   point_ff, point_in;
   logic                   float_ff, float_in;
   logic                   prev_point_ff, prev_point_in;

   // Result register
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_float_ff;
   logic                   rsp_neg_ff;
   logic [FracWidth-1:0]   rsp_frac_ff, rsp_frac_in;

   logic                   req_xfer;
   logic [PosWidth-1:0]    idx;
   logic [VALUE_WIDTH-1:0] digit_ext;
   logic [VALUE_WIDTH-1:0] dec_times_ten;
   logic [VALUE_WIDTH-1:0] rad_times_ten;
   logic [VALUE_WIDTH-1:0] rad_scaled;

   // Assertion helpers
   logic                   last_xfer;
   logic                   state_idle;
   logic                   rsp_int;

   // Take a character whenever the result register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign digit_ext     = {{(VALUE_WIDTH-4){1'b0}}, digit_of(req_char_code)};
   assign dec_times_ten = (dec_acc_ff << 3) + (dec_acc_ff << 1);
   assign rad_times_ten = (rad_acc_ff << 3) + (rad_acc_ff << 1);
   // Position of the character after the sign is stripped.
   assign idx           = pos_ff - {{(PosWidth-1){1'b0}}, minus_ff};

   always_comb begin
      case (kind_ff)
         RADIX_HEX: rad_scaled = rad_acc_ff << 4;
         RADIX_OCT: rad_scaled = rad_acc_ff << 3;
         RADIX_BIN: rad_scaled = rad_acc_ff << 1;
         default:   rad_scaled = rad_times_ten;
      endcase
   end

   // Next parse state for the character on the request port.
   always_comb begin
      pos_in        = pos_ff;
      minus_in      = minus_ff;
      kind_in       = kind_ff;
      dec_acc_in    = dec_acc_ff;
      rad_acc_in    = rad_acc_ff;
      frac_in       = frac_ff;
      point_in      = point_ff;
      float_in      = float_ff;
      prev_point_in = prev_point_ff;

      if (pos_ff == '0 && req_char_code == CharMinus) begin
         minus_in = 1'b1;
      end else begin
         // A point after the first stripped character, followed by any character, marks a float.
         if (prev_point_ff) begin
            float_in = 1'b1;
         end
         if (req_char_code == CharPoint) begin
            point_in      = 1'b1;
            frac_in       = '0;
            prev_point_in = (idx != '0);
         end else begin
            prev_point_in = 1'b0;
            dec_acc_in    = dec_times_ten + digit_ext;
            if (point_ff && frac_ff != FracMax) begin
               frac_in = frac_ff + 1'b1;
            end
            if (idx == '0) begin
               if (req_char_code == CharZero) begin
                  kind_in = RADIX_OCT;
               end else begin
                  rad_acc_in = rad_times_ten + digit_ext;
               end
            end else if (idx == PosWidth'(1) && kind_ff == RADIX_OCT &&
                         (req_char_code == CharLowX || req_char_code == CharUpX)) begin
               kind_in = RADIX_HEX;
            end else if (idx == PosWidth'(1) && kind_ff == RADIX_OCT &&
                         (req_char_code == CharLowB || req_char_code == CharUpB)) begin
               kind_in = RADIX_BIN;
            end else begin
               rad_acc_in = rad_scaled + digit_ext;
            end
         end
      end

      if (pos_ff != PosMax) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // Result payload from the state that includes the last character.
   always_comb begin
      if (float_in) begin
         rsp_value_in = dec_acc_in;
         rsp_frac_in  = frac_in;
      end else begin
         rsp_value_in = minus_in ? ('0 - rad_acc_in) : rad_acc_in;
         rsp_frac_in  = '0;
      end
   end

   // Advance the parse state; drop it back to reset after the last character.
   always_ff @(posedge clock) begin
      if (reset || (req_xfer && req_last_char)) begin
         pos_ff        <= '0;
         minus_ff      <= 1'b0;
         kind_ff       <= RADIX_DEC;
         dec_acc_ff    <= '0;
         rad_acc_ff    <= '0;
         frac_ff       <= '0;
         point_ff      <= 1'b0;
         float_ff      <= 1'b0;
         prev_point_ff <= 1'b0;
      end else if (req_xfer) begin
         pos_ff        <= pos_in;
         minus_ff      <= minus_in;
         kind_ff       <= kind_in;
         dec_acc_ff    <= dec_acc_in;
         rad_acc_ff    <= rad_acc_in;
         frac_ff       <= frac_in;
         point_ff      <= point_in;
         float_ff      <= float_in;
         prev_point_ff <= prev_point_in;
      end
   end

   // Result valid: load on the last character, clear once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer && req_last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload: hold until replaced by the next literal.
   always_ff @(posedge clock) begin
      if (req_xfer && req_last_char) begin
         rsp_value_ff <= rsp_value_in;
         rsp_float_ff <= float_in;
         rsp_neg_ff   <= minus_in;
         rsp_frac_ff  <= rsp_frac_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_value           = rsp_value_ff;
   assign rsp_is_float        = rsp_float_ff;
   assign rsp_negative        = rsp_neg_ff;
   assign rsp_fraction_digits = rsp_frac_ff;

   assign last_xfer  = req_xfer && req_last_char;
   assign state_idle = pos_ff == '0 && !minus_ff && !float_ff && !point_ff &&
                       dec_acc_ff == '0 && rad_acc_ff == '0;
   assign rsp_int    = rsp_valid_ff && !rsp_float_ff;

   `NLP_ASSERT_NEXT(a_last_gives_result, last_xfer, rsp_valid_ff, "no result after last character")
   `NLP_ASSERT_NEXT(a_last_clears_state, last_xfer, state_idle, "parse state not cleared")
   `NLP_ASSERT_NEXT(a_no_spurious_result, !last_xfer && !rsp_valid_ff, !rsp_valid_ff, "stray result")
   `NLP_ASSERT(a_int_has_no_scale, rsp_int |-> rsp_frac_ff == '0, "integer result with a scale")

endmodule
